[rtl/tcs_pkg.sv]
package tcs_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_ARM       = 2'd0;
   localparam logic [1:0] CMD_CLEAR     = 2'd1;
   localparam logic [1:0] CMD_CLEAR_ALL = 2'd2;
   localparam logic [1:0] CMD_TICK      = 2'd3;

   // classified operations handed from the front to the back
   localparam logic [2:0] OP_ARM       = 3'd0;
   localparam logic [2:0] OP_CLEAR     = 3'd1;
   localparam logic [2:0] OP_CLEAR_ALL = 3'd2;
   localparam logic [2:0] OP_TICK      = 3'd3;
   localparam logic [2:0] OP_RECOMPUTE = 3'd4;

   localparam logic [15:0] NEXT_EXPIRE_CAP = 16'hFFFF;
   localparam logic [31:0] TICK_RESET      = 32'd1000;

   // widest timer index the queue entry carries (up to sixteen timers)
   localparam int unsigned IDX_MAX_W = 4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  timer_index;
      logic [30:0] timeout;
   } req_type;

   typedef struct packed {
      logic        expired_valid;
      logic [2:0]  expired_index;
      logic        any_timer_on;
      logic [15:0] ticks_to_next;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           op;
      logic [IDX_MAX_W-1:0] idx;
      logic [30:0]          timeout;
   } op_entry_type;

endpackage

[rtl/tcs_front.sv]
module tcs_front import tcs_pkg::*; #(
   parameter int unsigned NUM_TIMERS = 6
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         q_valid,
   output op_entry_type q_entry,
   input  logic         q_pop
);

   op_entry_type entry_ff [2];
   op_entry_type entry_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   logic [4:0]   idx_wide;
   logic         idx_ok;

   // classify: fold an arm or clear of a missing timer into a plain recompute
   always_comb begin
      idx_wide         = {2'b00, req_data.timer_index};
      idx_ok           = idx_wide < 5'(NUM_TIMERS);
      entry_in.idx     = IDX_MAX_W'(req_data.timer_index);
      entry_in.timeout = req_data.timeout;
      unique case (req_data.cmd)
         CMD_ARM:       entry_in.op = idx_ok ? OP_ARM : OP_RECOMPUTE;
         CMD_CLEAR:     entry_in.op = idx_ok ? OP_CLEAR : OP_RECOMPUTE;
         CMD_CLEAR_ALL: entry_in.op = OP_CLEAR_ALL;
         default:       entry_in.op = OP_TICK;
      endcase
   end

   assign req_stall = count_ff == 2'd2;
   assign push      = req_valid && !req_stall;
   assign q_valid   = count_ff != 2'd0;
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

[rtl/tcs_back.sv]
module tcs_back import tcs_pkg::*; #(
   parameter int unsigned NUM_TIMERS = 6
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  op_entry_type q_entry,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RECOMP = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [31:0]           tick_ff, tick_in;
   logic [NUM_TIMERS-1:0] mask_ff, mask_in;
   logic [NUM_TIMERS-1:0] fired_ff, fired_in;
   logic [15:0]           ne_ff, ne_in;
   logic                  flag_ff, flag_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic [31:0]           dl_ff [NUM_TIMERS];
   logic                  dl_we;
   logic [IW-1:0]         dl_waddr;
   logic [31:0]           dl_wdata;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [31:0]           dl_sel;
   logic [31:0]           diff;
   logic [31:0]           window;
   logic                  last_step;
   logic                  out_free;
   logic [IW-1:0]         first_idx;
   logic [NUM_TIMERS-1:0] fired_rest;
   logic [IW-1:0]         op_idx;

   assign dl_sel    = dl_ff[cnt_ff];
   assign diff      = dl_sel - tick_ff;
   assign window    = diff - {16'd0, ne_ff};
   assign last_step = cnt_ff == LAST_IDX;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign op_idx    = q_entry.idx[IW-1:0];

   // lowest pending event goes out first
   always_comb begin
      first_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (fired_ff[i]) begin
            first_idx = IW'(i);
         end
      end
      fired_rest = fired_ff & (fired_ff - NUM_TIMERS'(1));
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      mask_in      = mask_ff;
      fired_in     = fired_ff;
      ne_in        = ne_ff;
      flag_in      = flag_ff;
      cnt_in       = cnt_ff;
      dl_we        = 1'b0;
      dl_waddr     = op_idx;
      dl_wdata     = tick_ff + {1'b0, q_entry.timeout};
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               fired_in = '0;
               cnt_in   = '0;
               ne_in    = NEXT_EXPIRE_CAP;
               flag_in  = 1'b0;
               state_in = ST_RECOMP;
               unique case (q_entry.op)
                  OP_ARM: begin
                     dl_we           = 1'b1;
                     mask_in[op_idx] = 1'b1;
                  end
                  OP_CLEAR:     mask_in[op_idx] = 1'b0;
                  OP_CLEAR_ALL: mask_in = '0;
                  OP_TICK: begin
                     tick_in = tick_ff + 32'd1;
                     ne_in   = ne_ff;
                     flag_in = flag_ff;
                     if (!flag_ff) begin
                        state_in = ST_EMIT;
                     end else if (ne_ff > 16'd1) begin
                        ne_in    = ne_ff - 16'd1;
                        state_in = ST_EMIT;
                     end else begin
                        ne_in    = 16'd0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RECOMP: begin
            if (mask_ff[cnt_ff] && window[31]) begin
               ne_in   = diff[31] ? 16'd0 : diff[15:0];
               flag_in = 1'b1;
            end
            if (last_step) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         ST_SCAN: begin
            if (mask_ff[cnt_ff] && (diff == 32'd0 || diff[31])) begin
               mask_in[cnt_ff]  = 1'b0;
               fired_in[cnt_ff] = 1'b1;
            end
            if (last_step) begin
               cnt_in   = '0;
               ne_in    = NEXT_EXPIRE_CAP;
               flag_in  = 1'b0;
               state_in = ST_RECOMP;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.any_timer_on  = flag_ff;
               rsp_in.ticks_to_next = ne_ff;
               if (fired_ff == '0) begin
                  rsp_in.expired_valid = 1'b0;
                  rsp_in.expired_index = 3'd0;
                  rsp_in.last          = 1'b1;
                  state_in             = ST_IDLE;
               end else begin
                  rsp_in.expired_valid = 1'b1;
                  rsp_in.expired_index = 3'(first_idx);
                  rsp_in.last          = fired_rest == '0;
                  fired_in             = fired_rest;
                  if (fired_rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= TICK_RESET;
         mask_ff      <= '0;
         fired_ff     <= '0;
         ne_ff        <= NEXT_EXPIRE_CAP;
         flag_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         mask_ff      <= mask_in;
         fired_ff     <= fired_in;
         ne_ff        <= ne_in;
         flag_ff      <= flag_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (dl_we) begin
         dl_ff[dl_waddr] <= dl_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/tcp_connection_timer_set.sv]
// Flow: an arm or clear goes from the queue through the recompute walk to the
//   result beat; a tick that expires nothing goes straight to the result beat;
//   a tick that runs out walks a scan, then a recompute, before the first event
//   beat, then one event beat per cycle while the receiver does not stall.
// The back takes one command at a time, the walks visiting one deadline a cycle.
// Reset: synchronous, active high; tick count 1000, all timers off, window 65535.
module tcp_connection_timer_set import tcs_pkg::*; #(
   parameter int unsigned NUM_TIMERS = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Front: take request beats, turn each command into an operation and
   // hold up to two of them behind the one the back is working on; stall the
   // source only once both places are taken.
   logic         q_valid;
   logic         q_pop;
   op_entry_type q_entry;

   tcs_front #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   // Back: own the timer state. Walk the deadlines one per cycle, first to
   // pick out expired timers on a run-out tick, then to rebuild the window,
   // and drain the events through a registered result beat.
   tcs_back #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // never take an operation from an empty queue
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("operation taken from empty queue");

   // only expiry events may be followed by more beats of the same command
   a_nonlast_is_event : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> rsp_data.expired_valid)
      else $error("status beat not marked last");

   // a status beat carries index zero
   a_status_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.expired_valid) |-> (rsp_data.expired_index == 3'd0))
      else $error("status beat with nonzero index");

   // any result beat with no timer on reports the full window
   a_idle_window : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.any_timer_on) |-> (rsp_data.ticks_to_next == 16'hFFFF))
      else $error("window shrunk with no timer on");
`endif

endmodule

[tb/tcp_connection_timer_set_tb.sv]
module tcp_connection_timer_set_tb import tcs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned N_TIMERS = 6;
   // Cycles with no beat on either channel before the run is abandoned
   localparam int unsigned QUIET_LIMIT = 5000;
   // Beats per random phase
   localparam int unsigned PHASE_BEATS = 160;

   // Timer set predictor and store of expected status/event beats
   class timer_scoreboard;
      logic [31:0] tick_count;
      logic [5:0]  enabled;
      logic [31:0] deadline [N_TIMERS];
      logic [15:0] ticks_left;
      logic        window_on;
      rsp_type     expected_q [$];
      int unsigned mismatches;

      function new();
         tick_count = TICK_RESET;
         enabled    = '0;
         foreach (deadline[i]) deadline[i] = '0;
         ticks_left = NEXT_EXPIRE_CAP;
         window_on  = 1'b0;
         mismatches = 0;
      endfunction

      // Find the nearest enabled deadline inside the 65535-tick window
      function void refresh_window();
         logic [31:0] span;
         logic [31:0] gap;
         ticks_left = NEXT_EXPIRE_CAP;
         window_on  = 1'b0;
         for (int i = 0; i < N_TIMERS; i++) begin
            span = deadline[i] - (tick_count + {16'd0, ticks_left});
            gap  = deadline[i] - tick_count;
            if (enabled[i] && span[31]) begin
               ticks_left = gap[31] ? 16'd0 : gap[15:0];
               window_on  = 1'b1;
            end
         end
      endfunction

      function void note_request(req_type r);
         logic [2:0]  fired [$];
         logic [31:0] gap;
         rsp_type     e;
         case (r.cmd)
            CMD_ARM: begin
               if (r.timer_index < N_TIMERS) begin
                  enabled[r.timer_index]  = 1'b1;
                  deadline[r.timer_index] = tick_count + {1'b0, r.timeout};
               end
               refresh_window();
            end
            CMD_CLEAR: begin
               if (r.timer_index < N_TIMERS) enabled[r.timer_index] = 1'b0;
               refresh_window();
            end
            CMD_CLEAR_ALL: begin
               enabled = '0;
               refresh_window();
            end
            CMD_TICK: begin
               tick_count = tick_count + 32'd1;
               if (window_on) begin
                  if (ticks_left > 16'd1) begin
                     ticks_left = ticks_left - 16'd1;
                  end else begin
                     ticks_left = 16'd0;
                     for (int i = 0; i < N_TIMERS; i++) begin
                        gap = deadline[i] - tick_count;
                        if (enabled[i] && (gap == 32'd0 || gap[31])) begin
                           enabled[i] = 1'b0;
                           fired.push_back(3'(i));
                        end
                     end
                     refresh_window();
                  end
               end
            end
         endcase
         if (fired.size() == 0) begin
            e = '{1'b0, 3'd0, window_on, ticks_left, 1'b1};
            expected_q.push_back(e);
         end else begin
            foreach (fired[k]) begin
               e = '{1'b1, fired[k], window_on, ticks_left, k == fired.size() - 1};
               expected_q.push_back(e);
            end
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: valid=%0d idx=%0d on=%0d next=%0d last=%0d",
                        got.expired_valid, got.expired_index, got.any_timer_on,
                        got.ticks_to_next, got.last);
            return;
         end
         want = expected_q.pop_front();
         if (got.expired_valid !== want.expired_valid ||
             got.expired_index !== want.expired_index ||
             got.any_timer_on  !== want.any_timer_on  ||
             got.ticks_to_next !== want.ticks_to_next ||
             got.last          !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("result mismatch: expected valid=%0d idx=%0d on=%0d next=%0d last=%0d,",
                      want.expired_valid, want.expired_index, want.any_timer_on,
                      want.ticks_to_next, want.last);
               $display(" got valid=%0d idx=%0d on=%0d next=%0d last=%0d",
                        got.expired_valid, got.expired_index, got.any_timer_on,
                        got.ticks_to_next, got.last);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function bit clean();
         return mismatches == 0 && expected_q.size() == 0;
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   timer_scoreboard sb;
   int unsigned     send_idle_pct = 12;
   int unsigned     recv_idle_pct = 74;
   int unsigned     quiet_cycles  = 0;

   tcp_connection_timer_set #(
      .NUM_TIMERS(N_TIMERS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   // Receiver side: stall at random with the current phase's rate; one update per edge
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watch both channels at the edge; values read here are those held across the edge,
   // so the order of processes within the step does not matter
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // Watchdog: abandon the run once nothing has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Present one request beat and hold it until accepted. Idle cycles come first,
   // so valid is only ever lowered in a step where it is not also raised.
   task automatic send_beat(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic issue(input logic [1:0] cmd, input logic [2:0] idx,
                        input logic [30:0] timeout);
      req_type r;
      r.cmd         = cmd;
      r.timer_index = idx;
      r.timeout     = timeout;
      send_beat(r);
   endtask

   // Drop valid and hold off until every predicted beat has come back.
   // Always wait for a clock edge first, so the monitor has noted the last beat.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly short timeouts so that expiries happen often; a share near the window edge,
   // beyond it, and over the whole 31-bit range so that every bit is toggled
   function automatic logic [30:0] pick_timeout();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40) return 31'($urandom_range(20));
      if (sel < 60) return 31'($urandom_range(300));
      if (sel < 70) return 31'($urandom_range(65540, 65528));
      if (sel < 80) return 31'($urandom_range(70000));
      return 31'($urandom);
   endfunction

   function automatic req_type pick_request();
      req_type     r;
      int unsigned sel;
      sel           = $urandom_range(99);
      r.timeout     = 31'($urandom);
      r.timer_index = ($urandom_range(99) < 92) ? 3'($urandom_range(N_TIMERS - 1))
                                                : 3'($urandom_range(7, N_TIMERS));
      if (sel < 30) begin
         r.cmd     = CMD_ARM;
         r.timeout = pick_timeout();
      end else if (sel < 42) begin
         r.cmd = CMD_CLEAR;
      end else if (sel < 45) begin
         r.cmd = CMD_CLEAR_ALL;
      end else begin
         // tick carries junk in the unused fields
         r.cmd         = CMD_TICK;
         r.timer_index = 3'($urandom);
      end
      return r;
   endfunction

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: sender idles lightly, receiver stalls heavily
      send_idle_pct = 12;
      recv_idle_pct = 74;
      issue(CMD_TICK, 3'd0, 31'd0);              // tick with no timer on
      issue(CMD_ARM, 3'd0, 31'd0);               // deadline already reached: window 0
      issue(CMD_TICK, 3'd0, 31'd0);              // expires it
      issue(CMD_ARM, 3'd1, 31'd1);               // countdown at one
      issue(CMD_TICK, 3'd0, 31'd0);
      issue(CMD_ARM, 3'd6, 31'd5);               // index out of range
      issue(CMD_CLEAR, 3'd7, 31'd0);             // index out of range
      issue(CMD_ARM, 3'd2, 31'd65535);           // just outside the window
      issue(CMD_ARM, 3'd3, 31'd65534);           // just inside it
      issue(CMD_ARM, 3'd4, 31'h7FFF_FFFF);       // farthest deadline
      issue(CMD_CLEAR, 3'd3, 31'd0);
      issue(CMD_CLEAR_ALL, 3'd7, 31'h7FFF_FFFF);
      for (int i = 0; i < N_TIMERS; i++)         // all six fire on the same tick
         issue(CMD_ARM, 3'(i), 31'd2);
      issue(CMD_TICK, 3'd7, 31'h7FFF_FFFF);
      issue(CMD_TICK, 3'd0, 31'd0);
      issue(CMD_ARM, 3'd5, 31'd4);
      issue(CMD_ARM, 3'd0, 31'd2);
      issue(CMD_TICK, 3'd0, 31'd0);
      issue(CMD_TICK, 3'd0, 31'd0);              // timer 0 fires, timer 5 stays
      issue(CMD_CLEAR, 3'd5, 31'd0);
      drain();

      // Random phases: swap the idle rates, then run flat out
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 74 : 0;
         recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 12 : 0;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            send_beat(pick_request());
            // now and then hold off until the block has caught up
            if ($urandom_range(99) < 2) drain();
         end
         drain();
      end

      // Let any late beat show itself before the verdict
      repeat (2 * N_TIMERS + 8) @(posedge clock);
      if (sb.clean())
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
